// File: rtl/multi_term_row_substring_filter_macros.svh
// Assertion macros shared by the checker of the row substring filter.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef MULTI_TERM_ROW_SUBSTRING_FILTER_MACROS_SVH
`define MULTI_TERM_ROW_SUBSTRING_FILTER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define MTRSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MTRSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mtrsf_pkg.sv
// Shared constants, types and codes of the multi-term row substring filter.
// No dependencies.
package mtrsf_pkg;

    localparam int MAX_TERMS    = 8;
    localparam int MAX_TERM_LEN = 32;

    localparam int BYTE_W   = 8;
    localparam int WIN_W    = MAX_TERM_LEN * BYTE_W;
    localparam int LEN_W    = $clog2(MAX_TERM_LEN + 1);
    localparam int TERM_W   = 3;   // term_index field width
    localparam int POS_W    = 5;   // byte_position field width
    localparam int TLEN_W   = 6;   // term_length_value field width
    localparam int OP_W     = 2;
    localparam int ACT_W    = 4;
    localparam int CNT_W    = 32;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PAT_WRITE = 2'd0,
        OP_SET_LEN   = 2'd1,
        OP_ROW_ITEM  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMBINE_MODE = 1'd0,
        CFG_ACTIVE_TERMS = 1'd1
    } cfg_idx_t;

    // Per-term control for one accepted item
    typedef struct packed {
        logic              pat_we;
        logic              len_we;
        logic              byte_en;
        logic              row_done;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  fill;    // row fill including the current byte
    } term_ctrl_t;

endpackage

// File: rtl/mtrsf_win_cell.sv
// One byte cell of the sliding window chain; hands its byte to the older neighbor.
// Depends on mtrsf_pkg.
module mtrsf_win_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift_en,
    input  logic [mtrsf_pkg::BYTE_W-1:0] din,
    output logic [mtrsf_pkg::BYTE_W-1:0] q,
    output logic [mtrsf_pkg::BYTE_W-1:0] q_next
);
    import mtrsf_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = shift_en ? din : byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q      = byte_reg;
    assign q_next = byte_next;

endmodule

// File: rtl/mtrsf_term_cell.sv
// One search term: its pattern bytes, length, hit flag and tail comparator.
// Depends on mtrsf_pkg.
module mtrsf_term_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mtrsf_pkg::term_ctrl_t       ctrl,
    input  logic [mtrsf_pkg::WIN_W-1:0] window,   // window after the current byte
    output logic                        hit_now,
    output logic                        len_zero
);
    import mtrsf_pkg::*;

    logic [BYTE_W-1:0] pat_reg [MAX_TERM_LEN];
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              hit_reg;
    logic              hit_next;

    logic [LEN_W-1:0]   shift_amt;
    logic [WIN_W-1:0]   aligned;
    logic [MAX_TERM_LEN-1:0] pos_ok;
    logic               match;

    // Tail of the window moved down so that pattern byte k lines up with byte k
    always_comb
    begin
        shift_amt = LEN_W'(MAX_TERM_LEN) - len_reg;
        aligned   = window >> {shift_amt, 3'b000};
        for (int k = 0; k < MAX_TERM_LEN; k++)
        begin
            pos_ok[k] = (LEN_W'(k) >= len_reg) || (aligned[k*BYTE_W +: BYTE_W] == pat_reg[k]);
        end
        match = ctrl.byte_en && (len_reg != '0) && (len_reg <= ctrl.fill) && (&pos_ok);
    end

    always_comb
    begin
        hit_now  = hit_reg || match;
        hit_next = ctrl.row_done ? 1'b0 : hit_now;
        len_next = len_reg;
        if (ctrl.len_we)
        begin
            len_next = ctrl.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            hit_reg <= hit_next;
        end
    end

    // Pattern bytes hold no reset value
    always_ff @(posedge clk)
    begin
        if (ctrl.pat_we)
        begin
            pat_reg[ctrl.pos] <= ctrl.data;
        end
    end

    assign len_zero = (len_reg == '0);

endmodule

// File: rtl/multi_term_row_substring_filter.sv
// Top level of the multi-term row substring filter.
// Depends on mtrsf_pkg, mtrsf_win_cell and mtrsf_term_cell.
//
// channel   dir   handshake          payload
// s_*       in    s_tvalid/s_tready  s_tdata, s_tuser, s_tlast
// m_*       out   m_tvalid/m_tready  m_tdata
// cfg_*     in    cfg_valid/cfg_ready cfg_index, cfg_data
//
// One input item per cycle while s_tready is high; each row byte is shifted into the window chain and
// compared against every term tail in the cycle it is accepted.
// A row end loads the result register; the result shows in the cycle after the transfer.
// s_tready drops only while the result register is full and m_tready is low.
// Reset clears window, lengths, hits, counters and config; pattern bytes stay unknown.
module multi_term_row_substring_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // term_index[2:0], byte_position[7:3], data_byte[15:8],
    // term_length_value[21:16], zero[23:22]
    input  logic [mtrsf_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[1:0], byte_valid[2]
    input  logic [mtrsf_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                              s_tlast,   // row_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // row_index[31:0], row_selected[32], selected_total[64:33], zero[71:65]
    output logic [mtrsf_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mtrsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtrsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mtrsf_pkg::*;

    // input fields
    logic [TERM_W-1:0] in_term;
    logic [POS_W-1:0]  in_pos;
    logic [BYTE_W-1:0] in_byte;
    logic [TLEN_W-1:0] in_len;
    logic              in_byte_valid;
    op_t               in_op;

    logic in_xfer;
    logic row_item;
    logic byte_en;
    logic row_done;

    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    logic [LEN_W-1:0] fill_cur;

    logic             combine_mode_reg;
    logic             combine_mode_next;
    logic [ACT_W-1:0] active_terms_reg;
    logic [ACT_W-1:0] active_terms_next;

    logic [CNT_W-1:0] row_counter_reg;
    logic [CNT_W-1:0] row_counter_next;
    logic [CNT_W-1:0] sel_count_reg;
    logic [CNT_W-1:0] sel_count_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CNT_W-1:0] out_index_reg;
    logic [CNT_W-1:0] out_index_next;
    logic             out_sel_reg;
    logic             out_sel_next;
    logic [CNT_W-1:0] out_total_reg;
    logic [CNT_W-1:0] out_total_next;

    logic [WIN_W-1:0] win_q;
    logic [WIN_W-1:0] win_next;

    term_ctrl_t           term_ctrl [MAX_TERMS];
    logic [MAX_TERMS-1:0] term_hit;
    logic [MAX_TERMS-1:0] term_empty;
    logic [MAX_TERMS-1:0] term_active;
    logic [MAX_TERMS-1:0] term_ok;
    logic                 sel_any;
    logic                 sel_all;
    logic                 row_sel;

    assign in_term       = s_tdata[2:0];
    assign in_pos        = s_tdata[7:3];
    assign in_byte       = s_tdata[15:8];
    assign in_len        = s_tdata[21:16];
    assign in_op         = op_t'(s_tuser[OP_W-1:0]);
    assign in_byte_valid = s_tuser[2];

    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign row_item  = in_xfer && (in_op == OP_ROW_ITEM);
    assign byte_en   = row_item && in_byte_valid;
    assign row_done  = row_item && s_tlast;

    always_comb
    begin
        len_sat = (int'(in_len) > MAX_TERM_LEN) ? LEN_W'(MAX_TERM_LEN) : LEN_W'(in_len);
        fill_cur = fill_reg;
        if (byte_en && (fill_reg != LEN_W'(MAX_TERM_LEN)))
        begin
            fill_cur = fill_reg + LEN_W'(1);
        end
        // window keeps stale bytes across rows; the fill check masks them
        fill_next = row_done ? '0 : fill_cur;
    end

    // Window chain: newest byte enters the top cell
    for (genvar j = 0; j < MAX_TERM_LEN; j++)
    begin : g_win
        logic [BYTE_W-1:0] cell_din;
        if (j == MAX_TERM_LEN - 1)
        begin : g_head
            assign cell_din = in_byte;
        end
        else
        begin : g_body
            assign cell_din = win_q[(j+1)*BYTE_W +: BYTE_W];
        end
        mtrsf_win_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (byte_en),
            .din      (cell_din),
            .q        (win_q[j*BYTE_W +: BYTE_W]),
            .q_next   (win_next[j*BYTE_W +: BYTE_W])
        );
    end

    for (genvar t = 0; t < MAX_TERMS; t++)
    begin : g_term
        always_comb
        begin
            term_ctrl[t].pat_we   = in_xfer && (in_op == OP_PAT_WRITE)
                                    && (int'(in_term) == t) && (int'(in_pos) < MAX_TERM_LEN);
            term_ctrl[t].len_we   = in_xfer && (in_op == OP_SET_LEN) && (int'(in_term) == t);
            term_ctrl[t].byte_en  = byte_en;
            term_ctrl[t].row_done = row_done;
            term_ctrl[t].pos      = in_pos;
            term_ctrl[t].data     = in_byte;
            term_ctrl[t].len      = len_sat;
            term_ctrl[t].fill     = fill_cur;
        end
        mtrsf_term_cell u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (term_ctrl[t]),
            .window   (win_next),
            .hit_now  (term_hit[t]),
            .len_zero (term_empty[t])
        );
    end

    always_comb
    begin
        for (int t = 0; t < MAX_TERMS; t++)
        begin
            term_active[t] = (t < int'(active_terms_reg));
        end
        term_ok = term_hit | term_empty;
        sel_any = |(term_ok & term_active);
        sel_all = &(term_ok | ~term_active);
        row_sel = combine_mode_reg ? sel_all : sel_any;
    end

    always_comb
    begin
        combine_mode_next = combine_mode_reg;
        active_terms_next = active_terms_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COMBINE_MODE: combine_mode_next = cfg_data[0];
                CFG_ACTIVE_TERMS: active_terms_next = cfg_data[ACT_W-1:0];
                default:          ;
            endcase
        end

        row_counter_next = row_counter_reg;
        sel_count_next   = sel_count_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_index_next   = out_index_reg;
        out_sel_next     = out_sel_reg;
        out_total_next   = out_total_reg;
        if (row_done)
        begin
            row_counter_next = row_counter_reg + CNT_W'(1);
            sel_count_next   = sel_count_reg + CNT_W'(row_sel);
            out_valid_next   = 1'b1;
            out_index_next   = row_counter_reg;
            out_sel_next     = row_sel;
            out_total_next   = sel_count_reg + CNT_W'(row_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            combine_mode_reg <= 1'b0;
            active_terms_reg <= '0;
            row_counter_reg  <= '0;
            sel_count_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            fill_reg         <= fill_next;
            combine_mode_reg <= combine_mode_next;
            active_terms_reg <= active_terms_next;
            row_counter_reg  <= row_counter_next;
            sel_count_reg    <= sel_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_sel_reg   <= out_sel_next;
        out_total_reg <= out_total_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_total_reg, out_sel_reg, out_index_reg};

endmodule

// File: rtl/mtrsf_checker.sv
// Port-level checker for the row substring filter, bound to the top level.
// Depends on mtrsf_pkg and multi_term_row_substring_filter_macros.svh.
`include "multi_term_row_substring_filter_macros.svh"

module mtrsf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [mtrsf_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mtrsf_pkg::M_TDATA_W-1:0]   m_tdata
);
    import mtrsf_pkg::*;

    logic row_end_xfer;
    assign row_end_xfer = s_tvalid && s_tready && s_tlast
                          && (s_tuser[OP_W-1:0] == OP_ROW_ITEM);

    `MTRSF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `MTRSF_ASSERT(a_full_blocks_in, m_tvalid && !m_tready |-> !s_tready, "input taken while result register full")
    `MTRSF_ASSERT(a_result_cause, $rose(m_tvalid) |-> $past(row_end_xfer), "result without a row end transfer")
    `MTRSF_ASSERT(a_index_step, m_tvalid && m_tready |=> !m_tvalid || (m_tdata[31:0] == 32'($past(m_tdata[31:0]) + 32'd1)), "row index did not advance by one")

endmodule

bind multi_term_row_substring_filter mtrsf_checker u_checker (.*);
